@@ hdl/rsnh_pkg.sv @@
package rsnh_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int DIST_W  = 32;
    localparam int ID_W    = 4;

    // Internal widths: differences, shared multiplier, accumulator, results
    localparam int DIFF_W     = COORD_W + 1;          // end - start, start - origin
    localparam int CHUNK_W    = 16;                   // low slice fed to the narrow port
    localparam int MUL_B_W    = CHUNK_W + 1;          // signed narrow multiplier port
    localparam int PROD_W     = DIFF_W + MUL_B_W;     // 50-bit product
    localparam int ACC_W      = 82;                   // holds range * |den| and T
    localparam int DEN_W      = 49;                   // dir x edge, signed
    localparam int MAG_W      = DEN_W - 1;            // |den|, |unum|
    localparam int TNUM_W     = 66;                   // offset x edge, signed
    localparam int TMAG_W     = TNUM_W - 1;
    localparam int FRAC_SHIFT = 14;                   // Q.32 * 2^14 / Q.30 -> Q16.16
    localparam int SCALED_W   = TMAG_W + FRAC_SHIFT;  // 79
    localparam int RD_W       = DIST_W + MAG_W;       // range * |den|
    localparam int REM_W      = MAG_W;
    localparam int DIV_CNT_W  = $clog2(DIST_W);

    localparam logic [DIST_W-1:0] RANGE_RESET = 32'd6553600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_MAG,
        ST_TEST,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Multiply passes, in issue order
    typedef enum logic [3:0] {
        STEP_D0,
        STEP_D1,
        STEP_U0,
        STEP_U1,
        STEP_T0,
        STEP_T1,
        STEP_T2,
        STEP_T3,
        STEP_R0,
        STEP_R1,
        STEP_R2
    } step_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } mac_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32
    } mac_shift_t;

    typedef enum logic [2:0] {
        DEST_NONE,
        DEST_DEN,
        DEST_UNUM,
        DEST_TNUM,
        DEST_RD
    } mac_dest_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  a;
        logic signed [MUL_B_W-1:0] b;
        mac_op_t                   op;
        mac_shift_t                shift;
        mac_dest_t                 dest;
    } mac_req_t;

    typedef struct packed {
        mac_dest_t                dest;
        logic signed [ACC_W-1:0]  value;
    } mac_res_t;

endpackage

@@ hdl/rsnh_ifs.sv @@
interface rsnh_seg_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rsnh_pkg::COORD_W-1:0]   origin_x;
    logic signed [rsnh_pkg::COORD_W-1:0]   origin_y;
    logic signed [rsnh_pkg::DIR_W-1:0]     dir_x;
    logic signed [rsnh_pkg::DIR_W-1:0]     dir_y;
    logic signed [rsnh_pkg::COORD_W-1:0]   seg_start_x;
    logic signed [rsnh_pkg::COORD_W-1:0]   seg_start_y;
    logic signed [rsnh_pkg::COORD_W-1:0]   seg_end_x;
    logic signed [rsnh_pkg::COORD_W-1:0]   seg_end_y;
    logic                                  first_segment;
    logic                                  last_segment;
    logic [rsnh_pkg::ID_W-1:0]             ray_id;

    modport source (
        output valid, origin_x, origin_y, dir_x, dir_y, seg_start_x, seg_start_y,
               seg_end_x, seg_end_y, first_segment, last_segment, ray_id,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, dir_x, dir_y, seg_start_x, seg_start_y,
               seg_end_x, seg_end_y, first_segment, last_segment, ray_id,
        output ready
    );
endinterface

interface rsnh_result_if;
    logic                           valid;
    logic                           ready;
    logic [rsnh_pkg::DIST_W-1:0]    nearest_distance;
    logic                           hit_found;
    logic [rsnh_pkg::ID_W-1:0]      result_ray_id;

    modport source (
        output valid, nearest_distance, hit_found, result_ray_id,
        input  ready
    );
    modport sink (
        input  valid, nearest_distance, hit_found, result_ray_id,
        output ready
    );
endinterface

interface rsnh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rsnh_pkg::DIST_W-1:0]    ray_range;

    modport source (
        output valid, ray_range,
        input  ready
    );
    modport sink (
        input  valid, ray_range,
        output ready
    );
endinterface

@@ hdl/rsnh_mac.sv @@
module rsnh_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  rsnh_pkg::mac_req_t req,
    output rsnh_pkg::mac_res_t res
);

    logic signed [rsnh_pkg::PROD_W-1:0] prod_reg;
    logic signed [rsnh_pkg::PROD_W-1:0] prod_next;
    logic signed [rsnh_pkg::ACC_W-1:0]  acc_reg;
    logic signed [rsnh_pkg::ACC_W-1:0]  acc_next;
    logic signed [rsnh_pkg::ACC_W-1:0]  prod_ext;
    logic signed [rsnh_pkg::ACC_W-1:0]  prod_shifted;
    rsnh_pkg::mac_op_t                  op_reg;
    rsnh_pkg::mac_shift_t               shift_reg;
    rsnh_pkg::mac_dest_t                dest_reg;

    // Multiply this cycle's operands
    always_comb
    begin
        prod_next = $signed(req.a) * $signed(req.b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Delay the accumulate control to line up with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= rsnh_pkg::MAC_HOLD;
            shift_reg <= rsnh_pkg::SH_0;
            dest_reg  <= rsnh_pkg::DEST_NONE;
        end
        else
        begin
            op_reg    <= req.op;
            shift_reg <= req.shift;
            dest_reg  <= req.dest;
        end
    end

    // Align the product and fold it into the accumulator
    always_comb
    begin
        prod_ext = {{(rsnh_pkg::ACC_W - rsnh_pkg::PROD_W){prod_reg[rsnh_pkg::PROD_W-1]}},
                    prod_reg};
        case (shift_reg)
            rsnh_pkg::SH_16: prod_shifted = prod_ext <<< rsnh_pkg::CHUNK_W;
            rsnh_pkg::SH_32: prod_shifted = prod_ext <<< (2 * rsnh_pkg::CHUNK_W);
            default:         prod_shifted = prod_ext;
        endcase
        case (op_reg)
            rsnh_pkg::MAC_LOAD: acc_next = prod_shifted;
            rsnh_pkg::MAC_ADD:  acc_next = acc_reg + prod_shifted;
            rsnh_pkg::MAC_SUB:  acc_next = acc_reg - prod_shifted;
            default:            acc_next = acc_reg;
        endcase
        res.dest  = (op_reg == rsnh_pkg::MAC_HOLD) ? rsnh_pkg::DEST_NONE : dest_reg;
        res.value = acc_next;
    end

endmodule

@@ hdl/ray_segment_nearest_hit.sv @@
// Casts one ray against a stream of 2D segments, one segment per item, and
// reports the nearest hit distance (Q16.16) with a hit flag and the ray tag
// when an item carries the last mark; first_segment restarts the minimum at
// ray_range. Segments are taken one at a time: seg_in.ready is high only
// while idle. For every item, eleven passes through one shared 33x17
// multiplier build the cross products and range * |den|; only a hit then
// runs a restoring divider that retires one quotient bit per cycle to form
// the distance; a segment that is missed, parallel or out of range skips it.
// A result waits in an output register, so the next segment is accepted
// while it is pending; the block stalls only if a second result is ready
// before the first is taken. The user must see that ray_range is written
// through cfg only while idle; the block itself does not enforce this.
module ray_segment_nearest_hit (
    input  logic               clk,
    input  logic               rst_n,
    rsnh_seg_if.sink           seg_in,
    rsnh_result_if.source      result_out,
    rsnh_cfg_if.sink           cfg
);

    rsnh_pkg::state_t state_reg, state_next;
    rsnh_pkg::step_t  step_reg, step_next;

    logic signed [rsnh_pkg::DIFF_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic signed [rsnh_pkg::DIFF_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic signed [rsnh_pkg::DIR_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic                                last_reg, last_next;
    logic [rsnh_pkg::ID_W-1:0]           id_reg, id_next;

    logic signed [rsnh_pkg::DEN_W-1:0]   den_reg, den_next;
    logic signed [rsnh_pkg::DEN_W-1:0]   unum_reg, unum_next;
    logic signed [rsnh_pkg::TNUM_W-1:0]  tnum_reg, tnum_next;
    logic [rsnh_pkg::RD_W-1:0]           rd_reg, rd_next;
    logic [rsnh_pkg::MAG_W-1:0]          dmag_reg, dmag_next;
    logic [rsnh_pkg::TMAG_W-1:0]         tmag_reg, tmag_next;
    logic                                cand_reg, cand_next;
    logic [rsnh_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [rsnh_pkg::DIST_W-1:0]         low_reg, low_next;
    logic [rsnh_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;

    logic [rsnh_pkg::DIST_W-1:0]         range_reg, range_next;
    logic [rsnh_pkg::DIST_W-1:0]         nearest_reg, nearest_next;
    logic                                any_hit_reg, any_hit_next;

    logic                                out_valid_reg, out_valid_next;
    logic [rsnh_pkg::DIST_W-1:0]         out_dist_reg, out_dist_next;
    logic                                out_hit_reg, out_hit_next;
    logic [rsnh_pkg::ID_W-1:0]           out_id_reg, out_id_next;

    rsnh_pkg::mac_req_t                  mac_req;
    rsnh_pkg::mac_res_t                  mac_res;

    logic                                accept;
    logic                                out_free;
    logic                                dneg, tneg, uneg;
    logic [rsnh_pkg::DEN_W-1:0]          dmag_full, umag_full;
    logic [rsnh_pkg::TNUM_W-1:0]         tmag_full;
    logic                                t_ok, u_ok;
    logic [rsnh_pkg::SCALED_W-1:0]       scaled;
    logic                                in_range;
    logic [rsnh_pkg::REM_W:0]            div_trial;
    logic [rsnh_pkg::REM_W+1:0]          div_diff;
    logic                                qbit;

    rsnh_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .res   (mac_res)
    );

    assign accept   = seg_in.valid && seg_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;

    assign cfg.ready                   = 1'b1;
    assign result_out.valid            = out_valid_reg;
    assign result_out.nearest_distance = out_dist_reg;
    assign result_out.hit_found        = out_hit_reg;
    assign result_out.result_ray_id    = out_id_reg;

    // Sign and magnitude terms for the hit tests
    always_comb
    begin
        dneg      = den_reg[rsnh_pkg::DEN_W-1];
        dmag_full = dneg ? (~den_reg + 1'b1) : den_reg;
        uneg      = unum_reg[rsnh_pkg::DEN_W-1];
        umag_full = uneg ? (~unum_reg + 1'b1) : unum_reg;
        tneg      = tnum_reg[rsnh_pkg::TNUM_W-1];
        tmag_full = tneg ? (~tnum_reg + 1'b1) : tnum_reg;
        t_ok      = !(|tnum_reg) || (tneg == dneg);
        u_ok      = !(|unum_reg) ||
                    ((uneg == dneg) && (umag_full[rsnh_pkg::MAG_W-1:0] <= dmag_reg));
        scaled    = {tmag_reg, {rsnh_pkg::FRAC_SHIFT{1'b0}}};
        in_range  = {1'b0, scaled} <= rd_reg;
        div_trial = {rem_reg, low_reg[rsnh_pkg::DIST_W-1]};
        div_diff  = {1'b0, div_trial} - {2'b00, dmag_reg};
        qbit      = !div_diff[rsnh_pkg::REM_W+1];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsnh_pkg::ST_IDLE:
                if (seg_in.valid)
                    state_next = rsnh_pkg::ST_MUL;
            rsnh_pkg::ST_MUL:
                if (step_reg == rsnh_pkg::STEP_R2)
                    state_next = rsnh_pkg::ST_DRAIN;
            rsnh_pkg::ST_DRAIN:
                state_next = rsnh_pkg::ST_MAG;
            rsnh_pkg::ST_MAG:
                state_next = rsnh_pkg::ST_TEST;
            rsnh_pkg::ST_TEST:
                state_next = (cand_reg && in_range) ? rsnh_pkg::ST_DIV : rsnh_pkg::ST_EMIT;
            rsnh_pkg::ST_DIV:
                if (div_cnt_reg == {rsnh_pkg::DIV_CNT_W{1'b1}})
                    state_next = rsnh_pkg::ST_UPDATE;
            rsnh_pkg::ST_UPDATE:
                state_next = rsnh_pkg::ST_EMIT;
            rsnh_pkg::ST_EMIT:
                if (!last_reg || out_free)
                    state_next = rsnh_pkg::ST_IDLE;
            default:
                state_next = rsnh_pkg::ST_IDLE;
        endcase
    end

    // Handshake and multiplier pass selection
    always_comb
    begin
        seg_in.ready  = (state_reg == rsnh_pkg::ST_IDLE);
        mac_req.a     = '0;
        mac_req.b     = '0;
        mac_req.op    = rsnh_pkg::MAC_HOLD;
        mac_req.shift = rsnh_pkg::SH_0;
        mac_req.dest  = rsnh_pkg::DEST_NONE;
        if (state_reg == rsnh_pkg::ST_MUL)
        begin
            unique case (step_reg)
                rsnh_pkg::STEP_D0:
                begin
                    mac_req.a  = ey_reg;
                    mac_req.b  = {dx_reg[rsnh_pkg::DIR_W-1], dx_reg};
                    mac_req.op = rsnh_pkg::MAC_LOAD;
                end
                rsnh_pkg::STEP_D1:
                begin
                    mac_req.a    = ex_reg;
                    mac_req.b    = {dy_reg[rsnh_pkg::DIR_W-1], dy_reg};
                    mac_req.op   = rsnh_pkg::MAC_SUB;
                    mac_req.dest = rsnh_pkg::DEST_DEN;
                end
                rsnh_pkg::STEP_U0:
                begin
                    mac_req.a  = ox_reg;
                    mac_req.b  = {dy_reg[rsnh_pkg::DIR_W-1], dy_reg};
                    mac_req.op = rsnh_pkg::MAC_LOAD;
                end
                rsnh_pkg::STEP_U1:
                begin
                    mac_req.a    = oy_reg;
                    mac_req.b    = {dx_reg[rsnh_pkg::DIR_W-1], dx_reg};
                    mac_req.op   = rsnh_pkg::MAC_SUB;
                    mac_req.dest = rsnh_pkg::DEST_UNUM;
                end
                rsnh_pkg::STEP_T0:
                begin
                    mac_req.a     = ox_reg;
                    mac_req.b     = ey_reg[rsnh_pkg::DIFF_W-1:rsnh_pkg::CHUNK_W];
                    mac_req.op    = rsnh_pkg::MAC_LOAD;
                    mac_req.shift = rsnh_pkg::SH_16;
                end
                rsnh_pkg::STEP_T1:
                begin
                    mac_req.a  = ox_reg;
                    mac_req.b  = {1'b0, ey_reg[rsnh_pkg::CHUNK_W-1:0]};
                    mac_req.op = rsnh_pkg::MAC_ADD;
                end
                rsnh_pkg::STEP_T2:
                begin
                    mac_req.a     = oy_reg;
                    mac_req.b     = ex_reg[rsnh_pkg::DIFF_W-1:rsnh_pkg::CHUNK_W];
                    mac_req.op    = rsnh_pkg::MAC_SUB;
                    mac_req.shift = rsnh_pkg::SH_16;
                end
                rsnh_pkg::STEP_T3:
                begin
                    mac_req.a    = oy_reg;
                    mac_req.b    = {1'b0, ex_reg[rsnh_pkg::CHUNK_W-1:0]};
                    mac_req.op   = rsnh_pkg::MAC_SUB;
                    mac_req.dest = rsnh_pkg::DEST_TNUM;
                end
                rsnh_pkg::STEP_R0:
                begin
                    mac_req.a  = {1'b0, range_reg};
                    mac_req.b  = {1'b0, dmag_reg[rsnh_pkg::CHUNK_W-1:0]};
                    mac_req.op = rsnh_pkg::MAC_LOAD;
                end
                rsnh_pkg::STEP_R1:
                begin
                    mac_req.a     = {1'b0, range_reg};
                    mac_req.b     = {1'b0, dmag_reg[2*rsnh_pkg::CHUNK_W-1:rsnh_pkg::CHUNK_W]};
                    mac_req.op    = rsnh_pkg::MAC_ADD;
                    mac_req.shift = rsnh_pkg::SH_16;
                end
                rsnh_pkg::STEP_R2:
                begin
                    mac_req.a     = {1'b0, range_reg};
                    mac_req.b     = {1'b0, dmag_reg[3*rsnh_pkg::CHUNK_W-1:2*rsnh_pkg::CHUNK_W]};
                    mac_req.op    = rsnh_pkg::MAC_ADD;
                    mac_req.shift = rsnh_pkg::SH_32;
                    mac_req.dest  = rsnh_pkg::DEST_RD;
                end
                default:
                begin
                    mac_req.op = rsnh_pkg::MAC_HOLD;
                end
            endcase
        end
    end

    // Datapath next values
    always_comb
    begin
        step_next      = step_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        last_next      = last_reg;
        id_next        = id_reg;
        den_next       = den_reg;
        unum_next      = unum_reg;
        tnum_next      = tnum_reg;
        rd_next        = rd_reg;
        dmag_next      = dmag_reg;
        tmag_next      = tmag_reg;
        cand_next      = cand_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        div_cnt_next   = div_cnt_reg;
        range_next     = range_reg;
        nearest_next   = nearest_reg;
        any_hit_next   = any_hit_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_dist_next  = out_dist_reg;
        out_hit_next   = out_hit_reg;
        out_id_next    = out_id_reg;

        // Take a register write
        if (cfg.valid)
            range_next = cfg.ray_range;

        // Latch the item and form the exact differences
        if (accept)
        begin
            step_next = rsnh_pkg::STEP_D0;
            ex_next   = {seg_in.seg_end_x[rsnh_pkg::COORD_W-1], seg_in.seg_end_x} -
                        {seg_in.seg_start_x[rsnh_pkg::COORD_W-1], seg_in.seg_start_x};
            ey_next   = {seg_in.seg_end_y[rsnh_pkg::COORD_W-1], seg_in.seg_end_y} -
                        {seg_in.seg_start_y[rsnh_pkg::COORD_W-1], seg_in.seg_start_y};
            ox_next   = {seg_in.seg_start_x[rsnh_pkg::COORD_W-1], seg_in.seg_start_x} -
                        {seg_in.origin_x[rsnh_pkg::COORD_W-1], seg_in.origin_x};
            oy_next   = {seg_in.seg_start_y[rsnh_pkg::COORD_W-1], seg_in.seg_start_y} -
                        {seg_in.origin_y[rsnh_pkg::COORD_W-1], seg_in.origin_y};
            dx_next   = seg_in.dir_x;
            dy_next   = seg_in.dir_y;
            last_next = seg_in.last_segment;
            id_next   = seg_in.ray_id;
            if (seg_in.first_segment)
            begin
                nearest_next = range_reg;
                any_hit_next = 1'b0;
            end
        end

        // Advance the multiply sequence and track |den|
        if (state_reg == rsnh_pkg::ST_MUL)
        begin
            dmag_next = dmag_full[rsnh_pkg::MAG_W-1:0];
            if (step_reg != rsnh_pkg::STEP_R2)
                step_next = rsnh_pkg::step_t'(step_reg + 4'd1);
        end

        // Store finished sums of products
        case (mac_res.dest)
            rsnh_pkg::DEST_DEN:  den_next  = mac_res.value[rsnh_pkg::DEN_W-1:0];
            rsnh_pkg::DEST_UNUM: unum_next = mac_res.value[rsnh_pkg::DEN_W-1:0];
            rsnh_pkg::DEST_TNUM: tnum_next = mac_res.value[rsnh_pkg::TNUM_W-1:0];
            rsnh_pkg::DEST_RD:   rd_next   = mac_res.value[rsnh_pkg::RD_W-1:0];
            default:             ;
        endcase

        // Decide whether the segment is a candidate hit
        if (state_reg == rsnh_pkg::ST_MAG)
        begin
            tmag_next = tmag_full[rsnh_pkg::TMAG_W-1:0];
            cand_next = (|den_reg) && t_ok && u_ok;
        end

        // Seed the divider with the high part of the scaled numerator
        if (state_reg == rsnh_pkg::ST_TEST)
        begin
            rem_next     = {1'b0, scaled[rsnh_pkg::SCALED_W-1:rsnh_pkg::DIST_W]};
            low_next     = scaled[rsnh_pkg::DIST_W-1:0];
            div_cnt_next = '0;
        end

        // One quotient bit per cycle
        if (state_reg == rsnh_pkg::ST_DIV)
        begin
            rem_next     = qbit ? div_diff[rsnh_pkg::REM_W-1:0] : div_trial[rsnh_pkg::REM_W-1:0];
            low_next     = {low_reg[rsnh_pkg::DIST_W-2:0], qbit};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        // Fold the hit into the running minimum
        if (state_reg == rsnh_pkg::ST_UPDATE)
        begin
            any_hit_next = 1'b1;
            if (low_reg < nearest_reg)
                nearest_next = low_reg;
        end

        // Hand the result to the output register
        if (state_reg == rsnh_pkg::ST_EMIT && last_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_dist_next  = nearest_reg;
            out_hit_next   = any_hit_reg;
            out_id_next    = id_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsnh_pkg::ST_IDLE;
            step_reg      <= rsnh_pkg::STEP_D0;
            div_cnt_reg   <= '0;
            range_reg     <= rsnh_pkg::RANGE_RESET;
            nearest_reg   <= '0;
            any_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            range_reg     <= range_next;
            nearest_reg   <= nearest_next;
            any_hit_reg   <= any_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        last_reg     <= last_next;
        id_reg       <= id_next;
        den_reg      <= den_next;
        unum_reg     <= unum_next;
        tnum_reg     <= tnum_next;
        rd_reg       <= rd_next;
        dmag_reg     <= dmag_next;
        tmag_reg     <= tmag_next;
        cand_reg     <= cand_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        out_dist_reg <= out_dist_next;
        out_hit_reg  <= out_hit_next;
        out_id_reg   <= out_id_next;
    end

    // An accepted item starts the multiply sequence at its first pass
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rsnh_pkg::ST_MUL && step_reg == rsnh_pkg::STEP_D0))
        else $error("accepted item did not start the multiply sequence");

    // The partial remainder stays below the divisor throughout the division
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsnh_pkg::ST_DIV) |-> (rem_reg < dmag_reg))
        else $error("divider remainder reached the divisor");

    // A new result appears only after a segment with the last mark
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rsnh_pkg::ST_EMIT && last_reg))
        else $error("result raised without a last segment");

endmodule
